// ===== rtl/tmom_pkg.sv =====
// ----------------------------------------------------------------------------
// tmom_pkg: shared constants and types of the one-mismatch tag map
// Table geometry, key and tag widths, status codes and the entry layout.
// ----------------------------------------------------------------------------
package tmom_pkg;

  localparam int TableEntries = 8192;
  localparam int SlotW        = $clog2(TableEntries);
  localparam int UsedW        = SlotW + 1;
  localparam int MaxTags      = 256;
  localparam int DigitChoices = 4;
  localparam int MaxTagDigits = 27;
  localparam int KeyW         = 63;
  localparam int TagW         = 8;
  localparam int LenW         = 5;
  localparam int StatusW      = 3;

  localparam logic [LenW-1:0] LenReset = 5'd15;

  // Multiplicative hash constant (golden ratio, 64 bits)
  localparam logic [63:0] HashMult = 64'h9E3779B97F4A7C15;

  localparam logic [StatusW-1:0] StInserted  = 3'd0;
  localparam logic [StatusW-1:0] StTooClose  = 3'd1;
  localparam logic [StatusW-1:0] StFull      = 3'd2;
  localparam logic [StatusW-1:0] StFound     = 3'd3;
  localparam logic [StatusW-1:0] StNotFound  = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
    logic [KeyW-1:0] key;
  } entry_t;

endpackage

// ===== rtl/tmom_ram.sv =====
// ----------------------------------------------------------------------------
// tmom_ram: hash table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmom_ram
  import tmom_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [SlotW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [TableEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tmom_hash.sv =====
// ----------------------------------------------------------------------------
// tmom_hash: home slot of a key
// Low product bits of key times the hash constant from three 21x21 partial
// products on one shared multiplier, then the fold of bits 41:29 onto 12:0.
// ----------------------------------------------------------------------------
module tmom_hash
  import tmom_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KeyW-1:0]  key_i,
  output logic             done_o,
  output logic [SlotW-1:0] slot_o
);

  localparam logic [20:0] MultLo = HashMult[20:0];
  localparam logic [20:0] MultHi = HashMult[41:21];

  logic [41:0] k_q, k_d;
  logic [41:0] acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        done_q, done_d;
  logic [20:0] op_a, op_b;
  logic [41:0] prod;

  always_comb begin
    op_a = k_q[20:0];
    op_b = MultLo;
    case (step_q)
      2'd2:    begin op_a = k_q[20:0];  op_b = MultHi; end
      2'd3:    begin op_a = k_q[41:21]; op_b = MultLo; end
      default: begin op_a = k_q[20:0];  op_b = MultLo; end
    endcase
  end

  assign prod = {21'b0, op_a} * {21'b0, op_b};

  always_comb begin
    k_d    = k_q;
    acc_d  = acc_q;
    step_d = step_q;
    done_d = 1'b0;
    case (step_q)
      2'd0: begin
        if (start_i) begin
          k_d    = key_i[41:0];
          step_d = 2'd1;
        end
      end
      2'd1: begin
        acc_d  = prod;
        step_d = 2'd2;
      end
      2'd2: begin
        acc_d[41:21] = acc_q[41:21] + prod[20:0];
        step_d       = 2'd3;
      end
      2'd3: begin
        acc_d[41:21] = acc_q[41:21] + prod[20:0];
        step_d       = 2'd0;
        done_d       = 1'b1;
      end
      default: step_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign slot_o = acc_q[SlotW-1:0] ^ acc_q[41:41-SlotW+1];

endmodule

// ===== rtl/tmom_div5.sv =====
// ----------------------------------------------------------------------------
// tmom_div5: divide a key by five
// Restoring division, eight dividend bits a cycle.
// ----------------------------------------------------------------------------
module tmom_div5
  import tmom_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [KeyW-1:0] val_i,
  output logic            done_o,
  output logic [KeyW-1:0] quot_o,
  output logic [2:0]      rem_o
);

  logic [63:0] sh_q, sh_d;
  logic [2:0]  rem_q, rem_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  always_comb begin
    logic [3:0] t;
    logic [2:0] r;
    logic [7:0] qb;
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r      = rem_q;
    qb     = '0;
    for (int b = 7; b >= 0; b--) begin
      t = {r, sh_q[56+b]};
      if (t >= 4'd5) begin
        qb[b] = 1'b1;
        r     = 3'(t - 4'd5);
      end else begin
        r     = t[2:0];
      end
    end
    if (busy_q) begin
      sh_d  = {sh_q[55:0], qb};
      rem_d = r;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      sh_d   = {1'b0, val_i};
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q[KeyW-1:0];
  assign rem_o  = rem_q;

endmodule

// ===== rtl/tag_map_one_mismatch.sv =====
// ----------------------------------------------------------------------------
// tag_map_one_mismatch: tag map with one-substitution neighbours
// Sequencer over a linear-probing hash table, a shared hash multiplier and
// a divide-by-five unit that peels off one base-5 digit per pass.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes tag_length (5 bits); the user must do so only while
//   the block is idle, and the block itself does not enforce it. s_axis
//   carries one request: tdata = key, tuser = operation (0 insert,
//   1 lookup). m_axis returns one result: tdata = tag number, tuser = status.
// Timing:
//   Each hash forms three partial products on one multiplier, each table
//   probe is a registered memory read, then a compare. s_axis_tready rises
//   with each result. An insert runs the exact-key search and the put of
//   the key, then per digit a division, the subtract of the digit and a
//   hash and put per neighbour. One request is in work at a time.
// Reset:
//   The table is cleared by a pass over every entry, one entry a cycle;
//   s_axis_tready stays low until it ends. tag_length returns to 15.
// Stall:
//   A held result sits in the output register; the next request is taken,
//   and its result waits, with s_axis_tready low, until m_axis_tready
//   drains the register.
// ----------------------------------------------------------------------------
module tag_map_one_mismatch
  import tmom_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LenW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // [62:0] key
  input  logic [0:0]         s_axis_tuser,   // [0] operation
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TagW-1:0]    m_axis_tdata,   // [7:0] tag_number
  output logic [StatusW-1:0] m_axis_tuser    // [2:0] status
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SUB   = 4'd6;
  localparam logic [3:0] S_NB    = 4'd7;
  localparam logic [3:0] S_ADV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableEntries - 1);

  logic [3:0]         state_q, state_d;
  logic [SlotW-1:0]   clr_q, clr_d;
  logic               op_q, op_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [KeyW-1:0]    cur_key_q, cur_key_d;
  logic               put_q, put_d;
  logic               main_q, main_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [SlotW-1:0]   n_q, n_d;
  logic [UsedW-1:0]   used_q, used_d;
  logic [8:0]         tag_count_q, tag_count_d;
  logic [LenW-1:0]    tag_len_q, tag_len_d;
  logic [LenW-1:0]    i_q, i_d;
  logic [63:0]        w_q, w_d;
  logic [63:0]        acc_q, acc_d;
  logic [KeyW-1:0]    q_q, q_d;
  logic [2:0]         d_q, d_d;
  logic [2:0]         sub_q, sub_d;
  logic [2:0]         c_q, c_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [TagW-1:0]    res_tag_q, res_tag_d;
  logic               m_valid_q, m_valid_d;
  logic [StatusW-1:0] m_status_q, m_status_d;
  logic [TagW-1:0]    m_tag_q, m_tag_d;
  logic               hash_start_q, hash_start_d;
  logic               div_start_q, div_start_d;

  logic               hash_done;
  logic [SlotW-1:0]   hash_slot;
  logic               div_done;
  logic [KeyW-1:0]    div_quot;
  logic [2:0]         div_rem;

  logic               ram_we;
  logic [SlotW-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  entry_t             ram_rdata;

  logic [LenW-1:0]    len;
  logic               no_space;
  logic               hit;
  logic               last_probe;
  logic               put_end;
  logic               ins_end;

  assign len = (tag_len_q > LenW'(MaxTagDigits)) ? LenW'(MaxTagDigits) : tag_len_q;
  assign no_space = (15'(used_q) + 15'(len) * 15'(DigitChoices) + 15'd1)
                    > 15'(TableEntries);
  assign hit        = ram_rdata.valid && (ram_rdata.key == cur_key_q);
  assign last_probe = (n_q == LastSlot);

  tmom_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .key_i   (cur_key_q),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  tmom_div5 u_div5 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .val_i   (q_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  tmom_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    key_d        = key_q;
    cur_key_d    = cur_key_q;
    put_d        = put_q;
    main_d       = main_q;
    slot_d       = slot_q;
    n_d          = n_q;
    used_d       = used_q;
    tag_count_d  = tag_count_q;
    tag_len_d    = tag_len_q;
    i_d          = i_q;
    w_d          = w_q;
    acc_d        = acc_q;
    q_d          = q_q;
    d_d          = d_q;
    sub_d        = sub_q;
    c_d          = c_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_tag_d      = m_tag_q;
    hash_start_d = 1'b0;
    div_start_d  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    s_axis_tready = 1'b0;
    put_end      = 1'b0;
    ins_end      = 1'b0;

    if (cfg_valid_i) begin
      tag_len_d = cfg_data_i;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d      = s_axis_tuser[0];
          key_d     = s_axis_tdata[KeyW-1:0];
          cur_key_d = s_axis_tdata[KeyW-1:0];
          put_d     = 1'b0;
          main_d    = 1'b0;
          if ((s_axis_tuser[0] == OpInsert) && (tag_count_q >= 9'(MaxTags))) begin
            res_status_d = StFull;
            res_tag_d    = '0;
            state_d      = S_DONE;
          end else begin
            hash_start_d = 1'b1;
            state_d      = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          slot_d  = hash_slot;
          n_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!put_q) begin
          if (hit) begin
            res_status_d = (op_q == OpLookup) ? StFound : StTooClose;
            res_tag_d    = (op_q == OpLookup) ? ram_rdata.tag : '0;
            state_d      = S_DONE;
          end else if (!ram_rdata.valid || last_probe) begin
            if (op_q == OpLookup) begin
              res_status_d = StNotFound;
              res_tag_d    = '0;
              state_d      = S_DONE;
            end else if (no_space) begin
              res_status_d = StFull;
              res_tag_d    = '0;
              state_d      = S_DONE;
            end else begin
              put_d        = 1'b1;
              main_d       = 1'b1;
              cur_key_d    = key_q;
              hash_start_d = 1'b1;
              state_d      = S_HASH;
            end
          end else begin
            slot_d  = slot_q + 1'b1;
            n_d     = n_q + 1'b1;
            state_d = S_RD;
          end
        end else begin
          if (!ram_rdata.valid || hit) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.tag   = tag_count_q[TagW-1:0];
            ram_wdata.key   = cur_key_q;
            if (!ram_rdata.valid) begin
              used_d = used_q + 1'b1;
            end
            put_end = 1'b1;
          end else if (last_probe) begin
            put_end = 1'b1;
          end else begin
            slot_d  = slot_q + 1'b1;
            n_d     = n_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          d_d     = div_rem;
          q_d     = div_quot;
          acc_d   = {1'b0, key_q};
          sub_d   = div_rem;
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        // strip the digit: acc = key - d * w
        if (sub_q != 3'd0) begin
          acc_d = acc_q - w_q;
          sub_d = sub_q - 3'd1;
        end else begin
          c_d     = '0;
          state_d = S_NB;
        end
      end
      S_NB: begin
        if (c_q == 3'(DigitChoices)) begin
          w_d = w_q + {w_q[61:0], 2'b00};
          i_d = i_q + 1'b1;
          if (LenW'(i_q + 1'b1) == len) begin
            ins_end = 1'b1;
          end else begin
            div_start_d = 1'b1;
            state_d     = S_DIV;
          end
        end else if (c_q == d_q) begin
          state_d = S_ADV;
        end else begin
          cur_key_d    = acc_q[KeyW-1:0];
          hash_start_d = 1'b1;
          state_d      = S_HASH;
        end
      end
      S_ADV: begin
        acc_d   = acc_q + w_q;
        c_d     = c_q + 3'd1;
        state_d = S_NB;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_tag_d    = res_tag_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (put_end) begin
      if (main_q) begin
        main_d = 1'b0;
        i_d    = '0;
        w_d    = 64'd1;
        q_d    = key_q;
        if (len == '0) begin
          ins_end = 1'b1;
        end else begin
          div_start_d = 1'b1;
          state_d     = S_DIV;
        end
      end else begin
        state_d = S_ADV;
      end
    end

    if (ins_end) begin
      tag_count_d  = tag_count_q + 1'b1;
      res_status_d = StInserted;
      res_tag_d    = tag_count_q[TagW-1:0];
      state_d      = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      used_q       <= '0;
      tag_count_q  <= '0;
      tag_len_q    <= LenReset;
      put_q        <= 1'b0;
      main_q       <= 1'b0;
      m_valid_q    <= 1'b0;
      hash_start_q <= 1'b0;
      div_start_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      used_q       <= used_d;
      tag_count_q  <= tag_count_d;
      tag_len_q    <= tag_len_d;
      put_q        <= put_d;
      main_q       <= main_d;
      m_valid_q    <= m_valid_d;
      hash_start_q <= hash_start_d;
      div_start_q  <= div_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    cur_key_q    <= cur_key_d;
    slot_q       <= slot_d;
    n_q          <= n_d;
    i_q          <= i_d;
    w_q          <= w_d;
    acc_q        <= acc_d;
    q_q          <= q_d;
    d_q          <= d_d;
    sub_q        <= sub_d;
    c_q          <= c_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    m_status_q   <= m_status_d;
    m_tag_q      <= m_tag_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tag_q;
  assign m_axis_tuser  = m_status_q;

endmodule
